// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: src/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared codes, character constants, beat types and the header name table
// of the HTTP request tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrt_pkg;

	// Default depth of the queues between the stages.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Token class codes, also used for the token that a byte closes.
	localparam logic [3:0] CLS_SEP      = 4'd0;
	localparam logic [3:0] CLS_METHOD   = 4'd1;
	localparam logic [3:0] CLS_URL      = 4'd2;
	localparam logic [3:0] CLS_KEY      = 4'd3;
	localparam logic [3:0] CLS_VALUE    = 4'd4;
	localparam logic [3:0] CLS_PROTOCOL = 4'd5;
	localparam logic [3:0] CLS_VERSION  = 4'd6;
	localparam logic [3:0] CLS_HDR_KEY  = 4'd7;
	localparam logic [3:0] CLS_HDR_VAL  = 4'd8;
	localparam logic [3:0] CLS_BODY     = 4'd9;

	// Status codes.
	localparam logic [1:0] STAT_BUSY     = 2'd0;
	localparam logic [1:0] STAT_COMPLETE = 2'd1;
	localparam logic [1:0] STAT_INVALID  = 2'd2;

	// Character constants.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	// Length of the Content-Length header name.
	localparam logic [3:0] NAME_LEN = 4'd14;

	// Input beat after classification.
	typedef struct packed {
		logic       restart;
		logic [7:0] data;
		logic       last;
		logic       is_cr;
		logic       is_lf;
		logic       is_blank;
		logic       is_space;
		logic       is_upper;
		logic       is_digit;
		logic       is_zero;
		logic       is_sign;
		logic       is_slash;
		logic       is_qmark;
		logic       is_amp;
		logic       is_eq;
		logic       is_colon;
		logic       is_dot;
	} front_item_t;

	// Result beat.
	typedef struct packed {
		logic [3:0] byte_class;
		logic [3:0] closes_token;
		logic [1:0] status;
	} result_t;

	// Characters of "Content-Length", by position.
	function automatic logic [7:0] name_char(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: src/hrt_queue.sv
// ----------------------------------------------------------------------------
// hrt_queue
// Small register-based first-in first-out queue that decouples two stages.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// Occupancy flags and qualified strobes.
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/hrt_front.sv
// ----------------------------------------------------------------------------
// hrt_front
// Accepts input beats, classifies each byte into character flags and holds
// the classified beats in a short queue for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrt_front import hrt_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	input  logic        item_pop,
	output front_item_t item,
	output logic        item_valid
);

	localparam int ITEM_W = $bits(front_item_t);

	front_item_t     cls_item;
	logic [ITEM_W-1:0] head_bits;
	logic            q_empty;

	// Character classification of the incoming byte.
	always_comb begin
		cls_item          = '0;
		cls_item.restart  = mode;
		cls_item.data     = data_byte;
		cls_item.last     = buffer_end;
		cls_item.is_cr    = (data_byte == CH_CR);
		cls_item.is_lf    = (data_byte == CH_LF);
		cls_item.is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
		cls_item.is_space = (data_byte == CH_SPACE) ||
			((data_byte >= CH_TAB) && (data_byte <= CH_CR));
		cls_item.is_upper = (data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z);
		cls_item.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		cls_item.is_zero  = (data_byte == CH_ZERO);
		cls_item.is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
		cls_item.is_slash = (data_byte == CH_SLASH);
		cls_item.is_qmark = (data_byte == CH_QMARK);
		cls_item.is_amp   = (data_byte == CH_AMP);
		cls_item.is_eq    = (data_byte == CH_EQ);
		cls_item.is_colon = (data_byte == CH_COLON);
		cls_item.is_dot   = (data_byte == CH_DOT);
	end

	// Queue of classified beats towards the parser.
	hrt_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_item_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cls_item),
		.full   (full),
		.rd_en  (item_pop),
		.rd_data(head_bits),
		.empty  (q_empty)
	);

	assign item       = front_item_t'(head_bits);
	assign item_valid = !q_empty;

endmodule

// File: src/hrt_back.sv
// ----------------------------------------------------------------------------
// hrt_back
// Request parser state machine with the Content-Length name matcher and the
// length value tracker. Consumes one classified beat per cycle, while the
// result queue has room, and produces one result beat for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrt_back import hrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  front_item_t item,
	input  logic        item_valid,
	output logic        item_pop,
	input  logic        res_full,
	output logic        res_push,
	output result_t     result
);

	// Parser state codes.
	localparam logic [4:0] S_START     = 5'd0;
	localparam logic [4:0] S_METHOD    = 5'd1;
	localparam logic [4:0] S_PRE_URL   = 5'd2;
	localparam logic [4:0] S_URL       = 5'd3;
	localparam logic [4:0] S_PRE_KEY   = 5'd4;
	localparam logic [4:0] S_KEY       = 5'd5;
	localparam logic [4:0] S_PRE_VAL   = 5'd6;
	localparam logic [4:0] S_VAL       = 5'd7;
	localparam logic [4:0] S_PRE_PROTO = 5'd8;
	localparam logic [4:0] S_PROTO     = 5'd9;
	localparam logic [4:0] S_PRE_VER   = 5'd10;
	localparam logic [4:0] S_VER       = 5'd11;
	localparam logic [4:0] S_HKEY      = 5'd12;
	localparam logic [4:0] S_HVAL      = 5'd13;
	localparam logic [4:0] S_CR        = 5'd14;
	localparam logic [4:0] S_CRLF      = 5'd15;
	localparam logic [4:0] S_CRLFCR    = 5'd16;
	localparam logic [4:0] S_BODY      = 5'd17;
	localparam logic [4:0] S_DONE      = 5'd18;
	localparam logic [4:0] S_BAD       = 5'd19;

	// Value tracker phases.
	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_DIG  = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;
	localparam logic [1:0] PH_SKIP = 2'd3;

	logic [4:0] state_q,    state_d;
	logic [3:0] pos_q,      pos_d;
	logic       ok_q,       ok_d;
	logic       seen_q,     seen_d;
	logic       nonzero_q,  nonzero_d;
	logic [1:0] phase_q,    phase_d;
	logic [3:0] cls;
	logic [3:0] clo;
	logic       key_hit;
	logic       first_hit;

	// A beat moves on whenever there is room for its result.
	assign item_pop = item_valid && !res_full;
	assign res_push = item_pop;

	// Name matcher compares against the expected character.
	assign key_hit   = ok_q && (pos_q < NAME_LEN) && (item.data == name_char(pos_q));
	assign first_hit = (item.data == name_char(4'd0));

	// Next state, trackers and result for the head beat.
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		ok_d      = ok_q;
		seen_d    = seen_q;
		nonzero_d = nonzero_q;
		phase_d   = phase_q;
		cls       = CLS_SEP;
		clo       = CLS_SEP;
		if (item.restart) begin
			state_d   = S_START;
			pos_d     = '0;
			ok_d      = 1'b1;
			seen_d    = 1'b0;
			nonzero_d = 1'b0;
			phase_d   = PH_LEAD;
		end else begin
			unique case (state_q)
				S_START: begin
					if (item.is_cr || item.is_lf || item.is_blank) begin
						state_d = S_START;
					end else if (item.is_upper) begin
						cls     = CLS_METHOD;
						state_d = S_METHOD;
					end else begin
						state_d = S_BAD;
					end
				end
				S_METHOD: begin
					if (item.is_upper) begin
						cls = CLS_METHOD;
					end else if (item.is_blank) begin
						clo     = CLS_METHOD;
						state_d = S_PRE_URL;
					end else begin
						state_d = S_BAD;
					end
				end
				S_PRE_URL: begin
					if (item.is_slash) begin
						cls     = CLS_URL;
						state_d = S_URL;
					end else if (!item.is_blank) begin
						state_d = S_BAD;
					end
				end
				S_URL: begin
					if (item.is_qmark) begin
						clo     = CLS_URL;
						state_d = S_PRE_KEY;
					end else if (item.is_blank) begin
						clo     = CLS_URL;
						state_d = S_PROTO;
					end else begin
						cls = CLS_URL;
					end
				end
				S_PRE_KEY: begin
					if (item.is_cr || item.is_lf || item.is_blank) begin
						state_d = S_BAD;
					end else begin
						cls     = CLS_KEY;
						state_d = S_KEY;
					end
				end
				S_KEY: begin
					if (item.is_eq) begin
						clo     = CLS_KEY;
						state_d = S_PRE_VAL;
					end else if (item.is_blank) begin
						state_d = S_BAD;
					end else begin
						cls = CLS_KEY;
					end
				end
				S_PRE_VAL: begin
					if (item.is_cr || item.is_lf || item.is_blank) begin
						state_d = S_BAD;
					end else begin
						cls     = CLS_VALUE;
						state_d = S_VAL;
					end
				end
				S_VAL: begin
					if (item.is_amp) begin
						clo     = CLS_VALUE;
						state_d = S_PRE_KEY;
					end else if (item.is_blank) begin
						clo     = CLS_VALUE;
						state_d = S_PRE_PROTO;
					end else begin
						cls = CLS_VALUE;
					end
				end
				S_PRE_PROTO: begin
					if (!item.is_blank) begin
						cls     = CLS_PROTOCOL;
						state_d = S_PROTO;
					end
				end
				S_PROTO: begin
					if (item.is_slash) begin
						clo     = CLS_PROTOCOL;
						state_d = S_PRE_VER;
					end else begin
						cls = CLS_PROTOCOL;
					end
				end
				S_PRE_VER: begin
					if (item.is_digit) begin
						cls     = CLS_VERSION;
						state_d = S_VER;
					end else begin
						state_d = S_BAD;
					end
				end
				S_VER: begin
					if (item.is_cr) begin
						clo     = CLS_VERSION;
						state_d = S_CR;
					end else if (item.is_digit || item.is_dot) begin
						cls = CLS_VERSION;
					end else begin
						state_d = S_BAD;
					end
				end
				S_CR: begin
					state_d = item.is_lf ? S_CRLF : S_BAD;
				end
				S_CRLF: begin
					if (item.is_cr) begin
						state_d = S_CRLFCR;
					end else if (item.is_blank) begin
						state_d = S_BAD;
					end else begin
						// First character of a header name restarts the matcher.
						cls     = CLS_HDR_KEY;
						state_d = S_HKEY;
						pos_d   = first_hit ? 4'd1 : 4'd0;
						ok_d    = first_hit;
					end
				end
				S_HKEY: begin
					if (item.is_colon) begin
						clo     = CLS_HDR_KEY;
						state_d = S_HVAL;
						ok_d    = ok_q && (pos_q == NAME_LEN);
						if (ok_q && (pos_q == NAME_LEN)) begin
							seen_d    = 1'b1;
							nonzero_d = 1'b0;
						end
						phase_d = PH_SKIP;
					end else begin
						cls = CLS_HDR_KEY;
						if (key_hit) begin
							pos_d = pos_q + 4'd1;
						end else begin
							ok_d = 1'b0;
						end
					end
				end
				S_HVAL: begin
					if (item.is_cr) begin
						clo     = CLS_HDR_VAL;
						state_d = S_CR;
					end else begin
						cls = (phase_q == PH_SKIP) ? CLS_SEP : CLS_HDR_VAL;
						if (ok_q) begin
							// Length value tracker.
							case (phase_q)
								PH_SKIP: phase_d = PH_LEAD;
								PH_LEAD: begin
									if (item.is_space) begin
										phase_d = PH_LEAD;
									end else if (item.is_sign || item.is_zero) begin
										phase_d = PH_DIG;
									end else if (item.is_digit) begin
										nonzero_d = 1'b1;
										phase_d   = PH_DIG;
									end else begin
										phase_d = PH_STOP;
									end
								end
								PH_DIG: begin
									if (item.is_zero) begin
										phase_d = PH_DIG;
									end else if (item.is_digit) begin
										nonzero_d = 1'b1;
									end else begin
										phase_d = PH_STOP;
									end
								end
								default: phase_d = phase_q;
							endcase
						end else if (phase_q == PH_SKIP) begin
							phase_d = PH_LEAD;
						end
					end
				end
				S_CRLFCR: begin
					if (item.is_lf) begin
						if (seen_q) begin
							state_d = nonzero_q ? S_BODY : S_DONE;
						end else begin
							state_d = item.last ? S_DONE : S_BODY;
						end
					end else begin
						state_d = S_BAD;
					end
				end
				S_BODY: begin
					cls = CLS_BODY;
					if (item.last) begin
						state_d = S_DONE;
					end
				end
				S_DONE: begin
					state_d = S_DONE;
				end
				default: begin
					state_d = S_BAD;
				end
			endcase
		end
	end

	// Result beat: an invalid request carries no token tags.
	always_comb begin
		result.byte_class   = (state_d == S_BAD) ? CLS_SEP : cls;
		result.closes_token = (state_d == S_BAD) ? CLS_SEP : clo;
		if (state_d == S_DONE) begin
			result.status = STAT_COMPLETE;
		end else if (state_d == S_BAD) begin
			result.status = STAT_INVALID;
		end else begin
			result.status = STAT_BUSY;
		end
	end

	// Parser and tracker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_START;
			pos_q     <= '0;
			ok_q      <= 1'b1;
			seen_q    <= 1'b0;
			nonzero_q <= 1'b0;
			phase_q   <= PH_LEAD;
		end else if (item_pop) begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			ok_q      <= ok_d;
			seen_q    <= seen_d;
			nonzero_q <= nonzero_d;
			phase_q   <= phase_d;
		end
	end

endmodule

// File: src/http_request_tokenizer_core.sv
// ----------------------------------------------------------------------------
// http_request_tokenizer_core
// Byte-serial HTTP/1.1 request tokenizer with queue interfaces on both sides.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock and returns one result beat per
// byte (token class, closed token, status), in order, sustaining one byte per
// cycle while results are popped. The accepted byte is registered in the input
// queue and waits at its head, where the parser state machine works on it, and
// its result is then registered in the result queue, from which it is shown on
// the output ports and can be popped; a full result queue holds the byte back.
// Full rises when the input queue holds QUEUE_DEPTH bytes, and empty stays low
// while the result queue holds a beat. Once a request is complete or invalid,
// every later byte returns that status until a restart beat (mode high).
`timescale 1ns / 1ps

module http_request_tokenizer_core import hrt_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       buffer_end,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] byte_class,
	output logic [3:0] closes_token,
	output logic [1:0] status
);

	`include "assert_macros.svh"

	localparam int RES_W = $bits(result_t);

	front_item_t       item;
	logic              item_valid;
	logic              item_pop;
	logic              res_full;
	logic              res_push;
	result_t           res_beat;
	logic [RES_W-1:0]  res_bits;
	result_t           head_res;

	// Front: accept and classify bytes.
	hrt_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.data_byte (data_byte),
		.buffer_end(buffer_end),
		.item_pop  (item_pop),
		.item      (item),
		.item_valid(item_valid)
	);

	// Back: parser state machine.
	hrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.result    (res_beat)
	);

	// Result queue towards the consumer.
	hrt_queue #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_beat),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_bits),
		.empty  (empty)
	);

	assign head_res     = result_t'(res_bits);
	assign byte_class   = head_res.byte_class;
	assign closes_token = head_res.closes_token;
	assign status       = head_res.status;

	// A finished or rejected request closes no token.
	`ASSERT_IMPLY(a_closed_no_token, clk, arst_n, (!empty && (status != STAT_BUSY)), (closes_token == CLS_SEP))
	// Invalid results carry no class.
	`ASSERT_IMPLY(a_invalid_no_class, clk, arst_n, (!empty && (status == STAT_INVALID)), (byte_class == CLS_SEP))
	// The parser never consumes a byte while the result queue is full.
	`ASSERT_IMPLY(a_no_pop_when_full, clk, arst_n, res_full, !item_pop)
	// Every consumed byte leaves a result waiting on the next cycle.
	`ASSERT_NEXT(a_result_follows, clk, arst_n, item_pop, !empty)

endmodule
